// ===== rtl/core/pmpa_pkg.sv =====
// Shared types and constants of the paged memory with page allocator.
// Request, status and controller state codes, plus default geometry.
// No dependencies.
package pmpa_pkg;

	localparam int PAGE_BYTES_DEF = 256;
	localparam int NUM_PAGES_DEF  = 64;
	// byte address in page 0 where the table pointer of process 0 sits
	localparam int TBL_PTR_BASE   = 64;

	typedef enum logic [1:0] {
		REQ_NEW   = 2'd0,
		REQ_KILL  = 2'd1,
		REQ_STORE = 2'd2,
		REQ_LOAD  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_TBL  = 2'd1,
		STAT_NO_DATA = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TBL_WAIT,
		S_PTE_WAIT,
		S_DATA_WAIT,
		S_KILL_RD,
		S_KILL_CHK,
		S_KILL_TBL,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_NP_PTR,
		S_NP_PTE
	} state_t;

endpackage

// ===== rtl/core/pmpa_mem.sv =====
// Single-port byte memory with registered read.
// Runs a clearing pass after reset (byte 0 set to one); ready goes high after it.
// Depends on pmpa_pkg for default geometry.
module pmpa_mem #(
	parameter int DEPTH = pmpa_pkg::PAGE_BYTES_DEF * pmpa_pkg::NUM_PAGES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata,
	output logic          ready
);
	import pmpa_pkg::*;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= (clr_addr_q == '0) ? 8'd1 : 8'd0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign ready = !clr_q;

endmodule

// ===== rtl/core/pmpa_ctrl.sv =====
// Request sequencer: allocator scan, kill walk and address translation.
// Drives the single memory port of pmpa_mem; one access per cycle.
// Depends on pmpa_pkg for codes and states.
module pmpa_ctrl #(
	parameter int PAGE_BYTES = pmpa_pkg::PAGE_BYTES_DEF,
	parameter int NUM_PAGES  = pmpa_pkg::NUM_PAGES_DEF,
	parameter int AW         = $clog2(PAGE_BYTES * NUM_PAGES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    req_type,
	input  logic [5:0]    pid,
	input  logic [7:0]    npages,
	input  logic [15:0]   vaddr,
	input  logic [7:0]    store_data,
	output logic          done,
	output logic [AW-1:0] xlat_addr,
	output logic [7:0]    read_data,
	output logic [1:0]    status,
	output logic          mem_we,
	output logic [AW-1:0] mem_addr,
	output logic [7:0]    mem_wdata,
	input  logic [7:0]    mem_rdata,
	input  logic          mem_ready
);
	import pmpa_pkg::*;

	localparam int PBW = $clog2(PAGE_BYTES);
	localparam int PW  = $clog2(NUM_PAGES);

	state_t          state_q, state_d;
	logic [1:0]      req_q;
	logic [5:0]      proc_q;
	logic [7:0]      cnt_q;
	logic [15:0]     va_q;
	logic [7:0]      data_q;
	logic [7:0]      tbl_q, tbl_d;
	logic [7:0]      pg_q, pg_d;
	logic [PW-1:0]   scan_q, scan_d;
	logic [7:0]      pte_q, pte_d;
	logic [PBW-1:0]  kidx_q, kidx_d;
	logic            alloc_tbl_q, alloc_tbl_d;
	logic [AW-1:0]   pa_q, pa_d;
	logic            accept;
	logic            fin;
	status_t         fin_status;
	logic [AW-1:0]   fin_pa;
	logic [7:0]      fin_rd;
	logic [AW-1:0]   xl_addr;
	logic            done_q;
	logic [AW-1:0]   xlat_addr_q;
	logic [7:0]      read_data_q;
	logic [1:0]      status_q;

	// page base plus offset, wrapped to the memory size
	function automatic logic [AW-1:0] addr_of(input logic [7:0] base,
	                                          input logic [AW-1:0] off);
		return (AW'(base) << PBW) + off;
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE) || !mem_ready;

	always_comb begin
		state_d     = state_q;
		tbl_d       = tbl_q;
		pg_d        = pg_q;
		scan_d      = scan_q;
		pte_d       = pte_q;
		kidx_d      = kidx_q;
		alloc_tbl_d = alloc_tbl_q;
		pa_d        = pa_q;
		mem_we      = 1'b0;
		mem_addr    = '0;
		mem_wdata   = '0;
		fin         = 1'b0;
		fin_status  = STAT_OK;
		fin_pa      = '0;
		fin_rd      = '0;
		xl_addr     = addr_of(mem_rdata, AW'(va_q[7:0]));
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_NEW) begin
						mem_addr    = AW'(1);
						scan_d      = PW'(1);
						alloc_tbl_d = 1'b1;
						state_d     = S_ALLOC_CHK;
					end else begin
						mem_addr = AW'(TBL_PTR_BASE) + AW'(pid);
						state_d  = S_TBL_WAIT;
					end
				end
			end
			S_TBL_WAIT: begin
				tbl_d = mem_rdata;
				if (req_q == REQ_KILL) begin
					mem_addr = addr_of(mem_rdata, '0);
					kidx_d   = '0;
					state_d  = S_KILL_CHK;
				end else begin
					mem_addr = addr_of(mem_rdata, AW'(va_q[15:8]));
					state_d  = S_PTE_WAIT;
				end
			end
			S_PTE_WAIT: begin
				mem_addr = xl_addr;
				pa_d     = xl_addr;
				if (req_q == REQ_STORE) begin
					mem_we    = 1'b1;
					mem_wdata = data_q;
					fin       = 1'b1;
					fin_pa    = xl_addr;
					state_d   = S_IDLE;
				end else begin
					state_d = S_DATA_WAIT;
				end
			end
			S_DATA_WAIT: begin
				fin     = 1'b1;
				fin_pa  = pa_q;
				fin_rd  = mem_rdata;
				state_d = S_IDLE;
			end
			S_KILL_RD: begin
				mem_addr = addr_of(tbl_q, AW'(kidx_q));
				state_d  = S_KILL_CHK;
			end
			S_KILL_CHK: begin
				// a free uses the port, so the next entry's read is issued from S_KILL_RD
				if (mem_rdata != '0 && mem_rdata < 8'(NUM_PAGES)) begin
					mem_we    = 1'b1;
					mem_addr  = AW'(mem_rdata);
					mem_wdata = '0;
					if (kidx_q == PBW'(PAGE_BYTES - 1)) begin
						state_d = S_KILL_TBL;
					end else begin
						kidx_d  = kidx_q + 1'b1;
						state_d = S_KILL_RD;
					end
				end else if (kidx_q == PBW'(PAGE_BYTES - 1)) begin
					state_d = S_KILL_TBL;
				end else begin
					kidx_d   = kidx_q + 1'b1;
					mem_addr = addr_of(tbl_q, AW'(PBW'(kidx_q + 1'b1)));
				end
			end
			S_KILL_TBL: begin
				if (tbl_q < 8'(NUM_PAGES)) begin
					mem_we    = 1'b1;
					mem_addr  = AW'(tbl_q);
					mem_wdata = '0;
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_ALLOC_RD: begin
				mem_addr = AW'(scan_q);
				state_d  = S_ALLOC_CHK;
			end
			S_ALLOC_CHK: begin
				if (mem_rdata == '0) begin
					mem_we    = 1'b1;
					mem_addr  = AW'(scan_q);
					mem_wdata = 8'd1;
					if (alloc_tbl_q) begin
						tbl_d   = 8'(scan_q);
						state_d = S_NP_PTR;
					end else begin
						pg_d    = 8'(scan_q);
						state_d = S_NP_PTE;
					end
				end else if (scan_q == PW'(NUM_PAGES - 1)) begin
					fin        = 1'b1;
					fin_status = alloc_tbl_q ? STAT_NO_TBL : STAT_NO_DATA;
					state_d    = S_IDLE;
				end else begin
					scan_d   = scan_q + 1'b1;
					mem_addr = AW'(PW'(scan_q + 1'b1));
				end
			end
			S_NP_PTR: begin
				mem_we    = 1'b1;
				mem_addr  = AW'(TBL_PTR_BASE) + AW'(proc_q);
				mem_wdata = tbl_q;
				if (cnt_q == '0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					pte_d       = '0;
					scan_d      = PW'(1);
					alloc_tbl_d = 1'b0;
					state_d     = S_ALLOC_RD;
				end
			end
			S_NP_PTE: begin
				mem_we    = 1'b1;
				mem_addr  = addr_of(tbl_q, AW'(pte_q));
				mem_wdata = pg_q;
				if (pte_q == cnt_q - 1'b1) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					pte_d   = pte_q + 1'b1;
					scan_d  = PW'(1);
					state_d = S_ALLOC_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			proc_q <= pid;
			cnt_q  <= npages;
			va_q   <= vaddr;
			data_q <= store_data;
		end
		tbl_q       <= tbl_d;
		pg_q        <= pg_d;
		scan_q      <= scan_d;
		pte_q       <= pte_d;
		kidx_q      <= kidx_d;
		alloc_tbl_q <= alloc_tbl_d;
		pa_q        <= pa_d;
		if (fin) begin
			xlat_addr_q <= fin_pa;
			read_data_q <= fin_rd;
			status_q    <= fin_status;
		end
	end

	assign done      = done_q;
	assign xlat_addr = xlat_addr_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_ready)
		else $error("memory write during clearing pass");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_alloc_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC_CHK && mem_we) |->
			(mem_wdata == 8'd1 && mem_addr < AW'(NUM_PAGES) && mem_addr != '0))
		else $error("allocator marked a byte outside the free map");

	a_rdata_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && req_q != REQ_LOAD) |-> (read_data_q == '0))
		else $error("read data on a non-load result");

endmodule

// ===== rtl/core/paged_memory_with_page_allocator.sv =====
// Top level: paged byte memory with first-free page allocator.
// Instantiates pmpa_ctrl (sequencer) and pmpa_mem (state memory).
// Depends on pmpa_pkg.
//
// Usage: drive a request on req_type/pid/npages/vaddr/store_data
// and raise start; the beat is taken at an edge where busy is low. Exactly
// one result beat follows, shown for one cycle with done high, carrying
// xlat_addr, read_data and status. The receiver cannot stall: done is a
// one-cycle strobe and the next request may be started once busy drops.
// Kill reads the table pointer, then walks all PAGE_BYTES entries, one per
// cycle while no page is freed; a free uses the port, so the next entry's
// read is issued from S_KILL_RD. The table page is freed last. New process
// scans the free map one byte per cycle for each page it takes, the table
// page first, and then records it. All of this is bound by the one port.
// After reset the memory is cleared, one byte per cycle, over all
// PAGE_BYTES*NUM_PAGES bytes (16384 by default); busy stays high until then.
// PAGE_BYTES and NUM_PAGES must be powers of two; the block does not check it.
module paged_memory_with_page_allocator #(
	parameter int PAGE_BYTES = pmpa_pkg::PAGE_BYTES_DEF,
	parameter int NUM_PAGES  = pmpa_pkg::NUM_PAGES_DEF,
	parameter int AW         = $clog2(PAGE_BYTES * NUM_PAGES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    req_type,
	input  logic [5:0]    pid,
	input  logic [7:0]    npages,
	input  logic [15:0]   vaddr,
	input  logic [7:0]    store_data,
	output logic          done,
	output logic [AW-1:0] xlat_addr,
	output logic [7:0]    read_data,
	output logic [1:0]    status
);
	import pmpa_pkg::*;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;
	logic          mem_ready;

	pmpa_ctrl #(
		.PAGE_BYTES (PAGE_BYTES),
		.NUM_PAGES  (NUM_PAGES),
		.AW         (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.pid        (pid),
		.npages     (npages),
		.vaddr      (vaddr),
		.store_data (store_data),
		.done       (done),
		.xlat_addr  (xlat_addr),
		.read_data  (read_data),
		.status     (status),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.mem_ready  (mem_ready)
	);

	pmpa_mem #(
		.DEPTH (PAGE_BYTES * NUM_PAGES),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.ready  (mem_ready)
	);

endmodule

// ===== tb/sv/pmpa_checker.sv =====
// Checker for the paged memory with page allocator: mirrors the memory,
// predicts one result beat per accepted request and compares each done beat.
// Depends on pmpa_pkg.
module pmpa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [5:0]  pid,
	input  logic [7:0]  npages,
	input  logic [15:0] vaddr,
	input  logic [7:0]  store_data,
	input  logic        done,
	input  logic [13:0] xlat_addr,
	input  logic [7:0]  read_data,
	input  logic [1:0]  status,
	output int          n_errors,
	output int          n_pending
);
	import pmpa_pkg::*;

	localparam int MEM_BYTES = PAGE_BYTES_DEF * NUM_PAGES_DEF;

	typedef struct packed {
		logic [13:0] paddr;
		logic [7:0]  rdata;
		status_t     stat;
	} mem_reply_t;

	logic [7:0] mirror [MEM_BYTES];
	mem_reply_t due_replies [$];
	int err_count;

	function automatic int wrap(int a);
		return a % MEM_BYTES;
	endfunction

	// first-free scan over the free map, page 0 never taken
	function automatic int take_page();
		for (int p = 1; p < NUM_PAGES_DEF; p++) begin
			if (mirror[p] == 8'd0) begin
				mirror[p] = 8'd1;
				return p;
			end
		end
		return -1;
	endfunction

	function automatic void release_page(int p);
		if (p < NUM_PAGES_DEF)
			mirror[p] = 8'd0;
	endfunction

	function automatic int map_addr(logic [5:0] proc, logic [15:0] va);
		int tbl;
		int ppage;
		tbl = mirror[TBL_PTR_BASE + proc];
		ppage = mirror[wrap(tbl * PAGE_BYTES_DEF + va[15:8])];
		return wrap(ppage * PAGE_BYTES_DEF + va[7:0]);
	endfunction

	function automatic mem_reply_t serve_request(req_t req, logic [5:0] proc,
			logic [7:0] cnt, logic [15:0] va, logic [7:0] data);
		mem_reply_t r;
		int tbl;
		int pg;
		int a;
		r = '0;
		r.stat = STAT_OK;
		case (req)
			REQ_NEW: begin
				tbl = take_page();
				if (tbl < 0) begin
					r.stat = STAT_NO_TBL;
				end else begin
					mirror[TBL_PTR_BASE + proc] = tbl[7:0];
					for (int i = 0; i < cnt; i++) begin
						pg = take_page();
						if (pg < 0) begin
							r.stat = STAT_NO_DATA;
							break;
						end
						mirror[wrap(tbl * PAGE_BYTES_DEF + i)] = pg[7:0];
					end
				end
			end
			REQ_KILL: begin
				tbl = mirror[TBL_PTR_BASE + proc];
				// each entry read after any earlier free of this walk
				for (int i = 0; i < PAGE_BYTES_DEF; i++) begin
					pg = mirror[wrap(tbl * PAGE_BYTES_DEF + i)];
					if (pg != 0)
						release_page(pg);
				end
				release_page(tbl);
			end
			REQ_STORE: begin
				a = map_addr(proc, va);
				mirror[a] = data;
				r.paddr = a[13:0];
			end
			default: begin
				a = map_addr(proc, va);
				r.paddr = a[13:0];
				r.rdata = mirror[a];
			end
		endcase
		return r;
	endfunction

	function automatic void note_mismatch(string what, int want, int got);
		err_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mem_reply_t got;
		mem_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEM_BYTES; i++)
				mirror[i] = 8'd0;
			mirror[0] = 8'd1;
			due_replies.delete();
			err_count = 0;
			n_pending <= 0;
			n_errors <= 0;
		end else begin
			if (done) begin
				got.paddr = xlat_addr;
				got.rdata = read_data;
				got.stat = status_t'(status);
				if (due_replies.size() == 0) begin
					note_mismatch("unexpected result beat, xlat_addr", 0, int'(got.paddr));
				end else begin
					want = due_replies.pop_front();
					if (got.paddr != want.paddr)
						note_mismatch("xlat_addr", int'(want.paddr), int'(got.paddr));
					if (got.rdata != want.rdata)
						note_mismatch("read_data", int'(want.rdata), int'(got.rdata));
					if (got.stat != want.stat)
						note_mismatch("status", int'(want.stat), int'(got.stat));
				end
			end
			if (start && !busy)
				due_replies.push_back(serve_request(req_t'(req_type), pid,
					npages, vaddr, store_data));
			n_pending <= due_replies.size();
			n_errors <= err_count;
		end
	end

endmodule

// ===== tb/sv/paged_memory_with_page_allocator_tb.sv =====
// Testbench top for the paged memory with page allocator: clock, reset,
// request stimulus, watchdog and verdict. Checking lives in pmpa_checker.
// Depends on pmpa_pkg, pmpa_checker and the block under test.
module paged_memory_with_page_allocator_tb;
	import pmpa_pkg::*;

	localparam int N_RANDOM = 880;
	localparam int STALL_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = '0;
	logic [5:0]  pid = '0;
	logic [7:0]  npages = '0;
	logic [15:0] vaddr = '0;
	logic [7:0]  store_data = '0;
	logic        busy;
	logic        done;
	logic [13:0] xlat_addr;
	logic [7:0]  read_data;
	logic [1:0]  status;

	int fail_count;
	int due_count;
	int stall_cycles = 0;
	bit quiet_run = 1'b0;
	// loose view of which processes hold a table and how many pages they asked for
	bit live [64];
	int span [64];

	always #4 clk = ~clk;

	paged_memory_with_page_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .pid(pid), .npages(npages),
		.vaddr(vaddr), .store_data(store_data), .done(done),
		.xlat_addr(xlat_addr), .read_data(read_data), .status(status)
	);

	pmpa_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .pid(pid), .npages(npages),
		.vaddr(vaddr), .store_data(store_data), .done(done),
		.xlat_addr(xlat_addr), .read_data(read_data), .status(status),
		.n_errors(fail_count), .n_pending(due_count)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("paged_memory_with_page_allocator_tb NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// called at a rising edge; returns at the edge that takes the beat
	task automatic issue(req_t req, logic [5:0] proc, logic [7:0] cnt,
			logic [15:0] va, logic [7:0] data);
		int gap;
		gap = quiet_run ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= req;
		pid <= proc;
		npages <= cnt;
		vaddr <= va;
		store_data <= data;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (req == REQ_NEW) begin
			live[proc] = 1'b1;
			span[proc] = int'(cnt);
		end else if (req == REQ_KILL) begin
			live[proc] = 1'b0;
		end
	endtask

	function automatic logic [5:0] pick_proc(bit want_live);
		logic [5:0] p;
		p = '0;
		for (int t = 0; t < 16; t++) begin
			p = 6'($urandom_range(0, 63));
			if (live[p] == want_live)
				return p;
		end
		return p;
	endfunction

	initial begin
		int pick;
		logic [5:0] p;
		logic [7:0] vpage;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// unmapped process: table pointer 0 walks page 0
		issue(REQ_LOAD, 6'd0, 8'd0, 16'h0000, 8'd0);
		issue(REQ_NEW, 6'd0, 8'd0, 16'h0000, 8'd0);
		issue(REQ_NEW, 6'd63, 8'd3, 16'hffff, 8'hff);
		issue(REQ_STORE, 6'd63, 8'hff, 16'h0000, 8'hff);
		issue(REQ_STORE, 6'd63, 8'd0, 16'h02ff, 8'h00);
		issue(REQ_STORE, 6'd63, 8'd0, 16'hffff, 8'ha5);
		issue(REQ_LOAD, 6'd63, 8'd0, 16'h0000, 8'd0);
		issue(REQ_LOAD, 6'd63, 8'd0, 16'h02ff, 8'd0);
		issue(REQ_LOAD, 6'd63, 8'd0, 16'hffff, 8'd0);
		// runs out of data pages, then out of table pages
		issue(REQ_NEW, 6'd1, 8'd255, 16'h0000, 8'd0);
		issue(REQ_NEW, 6'd2, 8'd1, 16'h0000, 8'd0);
		// plant an out-of-range table pointer for process 10: address wrap
		issue(REQ_STORE, 6'd10, 8'd0, 16'hf04a, 8'hc8);
		issue(REQ_LOAD, 6'd10, 8'd0, 16'h1234, 8'd0);
		issue(REQ_STORE, 6'd10, 8'd0, 16'h5678, 8'h3c);
		issue(REQ_KILL, 6'd10, 8'd0, 16'h0000, 8'd0);
		issue(REQ_KILL, 6'd1, 8'd0, 16'h0000, 8'd0);
		issue(REQ_KILL, 6'd63, 8'd0, 16'h0000, 8'd0);
		issue(REQ_KILL, 6'd0, 8'd0, 16'h0000, 8'd0);
		issue(REQ_KILL, 6'd0, 8'd0, 16'h0000, 8'd0);
		issue(REQ_KILL, 6'd5, 8'd0, 16'h0000, 8'd0);
		issue(REQ_NEW, 6'd5, 8'd4, 16'h0000, 8'd0);
		issue(REQ_LOAD, 6'd5, 8'd0, 16'h0300, 8'd0);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 64 == 0)
				quiet_run = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				issue(req_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			end else if (pick < 25) begin
				issue(REQ_NEW, pick_proc(1'b0),
					($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 6)),
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end else if (pick < 40) begin
				issue(REQ_KILL, pick_proc(1'b1), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end else begin
				p = pick_proc(1'b1);
				vpage = (span[p] > 0) ? 8'($urandom_range(0, span[p] - 1))
					: 8'($urandom_range(0, 255));
				issue((pick < 70) ? REQ_STORE : REQ_LOAD, p, 8'($urandom_range(0, 255)),
					{vpage, 8'($urandom_range(0, 255))}, 8'($urandom_range(0, 255)));
			end
		end
		start <= 1'b0;

		do @(posedge clk); while (due_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("paged_memory_with_page_allocator_tb OK");
		else
			$display("paged_memory_with_page_allocator_tb NOT OK");
		$finish;
	end

endmodule
